// ===== rtl/core/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

	// Field widths of the command and response transactions
	localparam int KIND_W   = 3;
	localparam int BLK_W    = 16;
	localparam int CNT_W    = 17;
	localparam int STATUS_W = 2;

	// Parameter defaults
	localparam int MAX_BLOCKS_DEF = 65536;
	localparam int WORD_BITS_DEF  = 64;

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [CNT_W-1:0] TOTAL_RST    = CNT_W'(65536);
	localparam logic [CNT_W-1:0] RESERVED_RST = '0;

	// Register indexes (taken from the word-aligned part of the address)
	localparam logic [0:0] REG_TOTAL    = 1'b0;
	localparam logic [0:0] REG_RESERVED = 1'b1;

	// Command kinds
	localparam logic [KIND_W-1:0] KIND_INIT  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FREE  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_WRITE = 3'd4;

	// Response status codes
	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

	// Register values handed from the configuration block to the sequencer
	typedef struct packed {
		logic [CNT_W-1:0] total;
		logic [CNT_W-1:0] reserved;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/bba_if.sv =====
`default_nettype none

interface bba_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [bba_pkg::KIND_W-1:0]  kind;
	logic [bba_pkg::BLK_W-1:0]   block_number;
	logic                        bit_value;

	modport source (output valid, output kind, output block_number, output bit_value,
		input ready);
	modport sink (input valid, input kind, input block_number, input bit_value,
		output ready);
endinterface

interface bba_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bba_pkg::BLK_W-1:0]    result_block;
	logic                         bit_read;
	logic [bba_pkg::CNT_W-1:0]    free_remaining;
	logic [bba_pkg::STATUS_W-1:0] status;

	modport source (output valid, output result_block, output bit_read,
		output free_remaining, output status, input ready);
	modport sink (input valid, input result_block, input bit_read,
		input free_remaining, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bitmap_block_allocator.sv =====
`default_nettype none

// Channel   Dir  Handshake                  Payload
// cmd       in   cmd.valid / cmd.ready      kind, block_number, bit_value
// rsp       out  rsp.valid / rsp.ready      result_block, bit_read, free_remaining, status
// apb       in   psel, penable, pwrite      paddr, pwdata -> prdata (pready tied high)
//
// Init writes one map word per cycle, then answers with the free count.
// Allocate scans for a clear bit, or answers without a scan when no block is free;
// the map read port reads one word a cycle.
// In-range free, read bit and write bit go through divide, split, read and modify-write.
// After reset the map is cleared while cmd.ready stays low.
// One command at a time; a finished result waits in the output register while the
// next command is accepted, and the next result stalls until that one is taken.

module bitmap_block_allocator #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
	parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bba_pkg::APB_AW-1:0]  paddr,
	input  wire logic [bba_pkg::APB_DW-1:0]  pwdata,
	output logic      [bba_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	bba_cmd_if.sink                          cmd,
	bba_rsp_if.source                        rsp
);

	localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	bba_pkg::cfg_t          cfg;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [WORD_BITS-1:0]   mem_wdata;
	logic                   mem_re;
	logic [AW-1:0]          mem_raddr;
	logic [WORD_BITS-1:0]   mem_rdata;

	bba_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bba_mem #(
		.DEPTH (MAP_WORDS),
		.WIDTH (WORD_BITS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bba_ctrl #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.WORD_BITS  (WORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// One command in flight: accepting a command drops ready on the next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command accepted while another is in flight");

	// A failed allocation returns no block and no bit
	a_nofree_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == bba_pkg::STATUS_NOFREE |->
			rsp.result_block == '0 && !rsp.bit_read)
		else $error("no-free response carries a block or bit");

	// An out-of-range access never returns a map bit
	a_range_no_bit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == bba_pkg::STATUS_RANGE |-> !rsp.bit_read)
		else $error("out-of-range response carries a map bit");

endmodule

`default_nettype wire

// ===== rtl/core/bba_mem.sv =====
`default_nettype none

module bba_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64,
	parameter int AW    = 10
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/bba_find.sv =====
`default_nettype none

module bba_find #(
	parameter int WORD_BITS = 64,
	parameter int PW        = 6,
	parameter int LW        = 7
) (
	input  wire logic [WORD_BITS-1:0] word,
	input  wire logic [LW-1:0]        lim,
	output logic                      found,
	output logic [PW-1:0]             pos
);

	// Pick the lowest clear position below lim, position 0 being the MSB
	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int p = WORD_BITS - 1; p >= 0; p--) begin
			if (!word[WORD_BITS-1-p] && (LW'(p) < lim)) begin
				found = 1'b1;
				pos   = PW'(p);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bba_cfg.sv =====
`default_nettype none

module bba_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bba_pkg::APB_AW-1:0]  paddr,
	input  wire logic [bba_pkg::APB_DW-1:0]  pwdata,
	output logic      [bba_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	output bba_pkg::cfg_t                    cfg
);

	logic [bba_pkg::CNT_W-1:0] total_q;
	logic [bba_pkg::CNT_W-1:0] reserved_q;
	logic [0:0]                reg_idx;
	logic                      wr_en;

	assign reg_idx = paddr[bba_pkg::APB_AW-1];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Store register writes at the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= bba_pkg::TOTAL_RST;
			reserved_q <= bba_pkg::RESERVED_RST;
		end else if (wr_en) begin
			case (reg_idx)
				bba_pkg::REG_TOTAL:    total_q    <= pwdata[bba_pkg::CNT_W-1:0];
				bba_pkg::REG_RESERVED: reserved_q <= pwdata[bba_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		case (reg_idx)
			bba_pkg::REG_TOTAL:    prdata = bba_pkg::APB_DW'(total_q);
			bba_pkg::REG_RESERVED: prdata = bba_pkg::APB_DW'(reserved_q);
			default:               prdata = '0;
		endcase
	end

	assign cfg.total    = total_q;
	assign cfg.reserved = reserved_q;

endmodule

`default_nettype wire

// ===== rtl/core/bba_ctrl.sv =====
`default_nettype none

module bba_ctrl #(
	parameter  int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
	parameter  int WORD_BITS  = bba_pkg::WORD_BITS_DEF,
	localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS,
	localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bba_pkg::cfg_t        cfg,
	bba_cmd_if.sink                   cmd,
	bba_rsp_if.source                 rsp,
	output logic                      mem_we,
	output logic [AW-1:0]             mem_waddr,
	output logic [WORD_BITS-1:0]      mem_wdata,
	output logic                      mem_re,
	output logic [AW-1:0]             mem_raddr,
	input  wire logic [WORD_BITS-1:0] mem_rdata
);

	localparam int WCW    = $clog2(MAP_WORDS + 1);
	localparam int PW     = $clog2(WORD_BITS);
	localparam int LW     = $clog2(WORD_BITS + 1);
	localparam int BSW    = $clog2(MAP_WORDS * WORD_BITS + 1);
	localparam int CNT_W  = bba_pkg::CNT_W;
	localparam int BLK_W  = bba_pkg::BLK_W;
	localparam int CW     = (BSW > CNT_W) ? BSW : CNT_W;
	localparam int DIV_SH = 24;
	localparam int RECIP  = (1 << DIV_SH) / WORD_BITS;
	localparam int RW     = $clog2(RECIP + 1);
	localparam int PRW    = BLK_W + RW;

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_SPLIT = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;
	localparam logic [2:0] ST_RMW   = 3'd6;
	localparam logic [2:0] ST_RESP  = 3'd7;

	localparam logic [WORD_BITS-1:0] MSB_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};

	logic [2:0]                     state_q;
	logic                           clr_q;
	logic [bba_pkg::KIND_W-1:0]     kind_q;
	logic [BLK_W-1:0]               blk_q;
	logic                           val_q;
	logic [CW-1:0]                  r_q;
	logic [WCW-1:0]                 w_q;
	logic [CW-1:0]                  base_q;
	logic                           vld_s1;
	logic [AW-1:0]                  addr_s1;
	logic [CW-1:0]                  base_s1;
	logic [BLK_W-1:0]               q_q;
	logic [AW-1:0]                  word_q;
	logic [PW-1:0]                  pos_q;
	logic [CNT_W-1:0]               free_q;
	logic [BLK_W-1:0]               res_block_q;
	logic                           res_bit_q;
	logic [bba_pkg::STATUS_W-1:0]   res_status_q;
	logic                           rsp_valid_q;
	logic [BLK_W-1:0]               rsp_block_q;
	logic                           rsp_bit_q;
	logic [CNT_W-1:0]               rsp_free_q;
	logic [bba_pkg::STATUS_W-1:0]   rsp_status_q;

	logic [CW-1:0]                  eff;
	logic [CW-1:0]                  res_ext;
	logic [LW-1:0]                  init_lim;
	logic [WORD_BITS-1:0]           init_word;
	logic                           scan_issue;
	logic [LW-1:0]                  scan_lim;
	logic                           found;
	logic [PW-1:0]                  found_pos;
	logic                           hit;
	logic [WORD_BITS-1:0]           found_mask;
	logic [WORD_BITS-1:0]           pos_mask;
	logic                           cur_bit;
	logic [PRW-1:0]                 prod;
	logic [BLK_W-1:0]               qw;
	logic [BLK_W-1:0]               rem;
	logic                           rsp_load;

	// Count of positions of a word that lie below hi, given the word's base
	function automatic logic [LW-1:0] sat_lim(input logic [CW-1:0] hi,
		input logic [CW-1:0] base);
		logic [CW-1:0] diff;
		diff = hi - base;
		if (hi <= base) begin
			sat_lim = '0;
		end else if (diff >= CW'(WORD_BITS)) begin
			sat_lim = LW'(WORD_BITS);
		end else begin
			sat_lim = LW'(diff);
		end
	endfunction

	// Cap the configured total at the map size
	assign eff     = (CW'(cfg.total) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(cfg.total);
	assign res_ext = CW'(cfg.reserved);

	// Build one word of the init image: reserved blocks set, MSB first
	assign init_lim = sat_lim(r_q, base_q);
	always_comb begin
		for (int p = 0; p < WORD_BITS; p++) begin
			init_word[WORD_BITS-1-p] = (LW'(p) < init_lim);
		end
	end

	// Scan: one read per cycle, evaluate each returned word in the cycle after its read
	assign scan_issue = (state_q == ST_SCAN) && (base_q < eff);
	assign scan_lim   = sat_lim(eff, base_s1);

	bba_find #(
		.WORD_BITS (WORD_BITS),
		.PW        (PW),
		.LW        (LW)
	) u_find (
		.word  (mem_rdata),
		.lim   (scan_lim),
		.found (found),
		.pos   (found_pos)
	);

	assign hit        = (state_q == ST_SCAN) && vld_s1 && found;
	assign found_mask = MSB_BIT >> found_pos;
	assign pos_mask   = MSB_BIT >> pos_q;
	assign cur_bit    = |(mem_rdata & pos_mask);

	// Split a block number into word and position via reciprocal multiply
	assign prod = PRW'(blk_q) * PRW'(RECIP);
	assign qw   = q_q * BLK_W'(WORD_BITS);
	assign rem  = blk_q - qw;

	// Drive the map port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(w_q);
		mem_wdata = init_word;
		mem_re    = 1'b0;
		mem_raddr = AW'(w_q);
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
			end
			ST_SCAN: begin
				mem_re = scan_issue;
				if (hit) begin
					mem_we    = 1'b1;
					mem_waddr = addr_s1;
					mem_wdata = mem_rdata | found_mask;
				end
			end
			ST_READ: begin
				mem_re    = 1'b1;
				mem_raddr = word_q;
			end
			ST_RMW: begin
				mem_waddr = word_q;
				if (kind_q == bba_pkg::KIND_FREE) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata & ~pos_mask;
				end else if (kind_q == bba_pkg::KIND_WRITE) begin
					mem_we    = 1'b1;
					mem_wdata = val_q ? (mem_rdata | pos_mask) : (mem_rdata & ~pos_mask);
				end
			end
			default: ;
		endcase
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign rsp_load  = (state_q == ST_RESP) && (!rsp_valid_q || rsp.ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q   <= 1'b1;
			r_q     <= '0;
			w_q     <= '0;
			base_q  <= '0;
			vld_s1  <= 1'b0;
			free_q  <= '0;
		end else begin
			vld_s1 <= scan_issue && !hit;
			case (state_q)
				ST_INIT: begin
					w_q    <= w_q + WCW'(1);
					base_q <= base_q + CW'(WORD_BITS);
					if (w_q == WCW'(MAP_WORDS - 1)) begin
						if (clr_q) begin
							clr_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							free_q  <= CNT_W'(eff - r_q);
							state_q <= ST_RESP;
						end
					end
				end
				ST_IDLE: begin
					w_q    <= '0;
					base_q <= '0;
					if (cmd.valid) begin
						case (cmd.kind)
							bba_pkg::KIND_INIT: begin
								r_q     <= (res_ext < eff) ? res_ext : eff;
								state_q <= ST_INIT;
							end
							bba_pkg::KIND_ALLOC: begin
								state_q <= (free_q == '0) ? ST_RESP : ST_SCAN;
							end
							bba_pkg::KIND_FREE, bba_pkg::KIND_READ, bba_pkg::KIND_WRITE: begin
								state_q <= (CW'(cmd.block_number) >= eff) ? ST_RESP : ST_DIV;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						w_q    <= w_q + WCW'(1);
						base_q <= base_q + CW'(WORD_BITS);
					end
					if (hit) begin
						free_q  <= free_q - CNT_W'(1);
						state_q <= ST_RESP;
					end else if (!vld_s1 && !scan_issue) begin
						state_q <= ST_RESP;
					end
				end
				ST_DIV: begin
					state_q <= ST_SPLIT;
				end
				ST_SPLIT: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_RMW;
				end
				ST_RMW: begin
					if (kind_q == bba_pkg::KIND_FREE && CW'(free_q) < eff) begin
						free_q <= free_q + CNT_W'(1);
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the command and build the result
	always_ff @(posedge clk) begin
		addr_s1 <= AW'(w_q);
		base_s1 <= base_q;
		case (state_q)
			ST_IDLE: begin
				kind_q       <= cmd.kind;
				blk_q        <= cmd.block_number;
				val_q        <= cmd.bit_value;
				res_block_q  <= '0;
				res_bit_q    <= 1'b0;
				res_status_q <= bba_pkg::STATUS_OK;
				case (cmd.kind)
					bba_pkg::KIND_ALLOC: begin
						if (free_q == '0) begin
							res_status_q <= bba_pkg::STATUS_NOFREE;
						end
					end
					bba_pkg::KIND_FREE, bba_pkg::KIND_READ, bba_pkg::KIND_WRITE: begin
						res_block_q <= cmd.block_number;
						if (CW'(cmd.block_number) >= eff) begin
							res_status_q <= bba_pkg::STATUS_RANGE;
						end
					end
					default: ;
				endcase
			end
			ST_SCAN: begin
				if (hit) begin
					res_block_q <= BLK_W'(base_s1 + CW'(found_pos));
				end else if (!vld_s1 && !scan_issue) begin
					res_status_q <= bba_pkg::STATUS_NOFREE;
				end
			end
			ST_DIV: begin
				q_q <= BLK_W'(prod >> DIV_SH);
			end
			ST_SPLIT: begin
				if (rem >= BLK_W'(WORD_BITS)) begin
					word_q <= AW'(q_q + BLK_W'(1));
					pos_q  <= PW'(rem - BLK_W'(WORD_BITS));
				end else begin
					word_q <= AW'(q_q);
					pos_q  <= PW'(rem);
				end
			end
			ST_RMW: begin
				res_bit_q <= (kind_q == bba_pkg::KIND_READ) ? cur_bit : 1'b0;
			end
			default: ;
		endcase
	end

	// Output register: load a finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_block_q  <= res_block_q;
			rsp_bit_q    <= res_bit_q;
			rsp_free_q   <= free_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.result_block   = rsp_block_q;
	assign rsp.bit_read       = rsp_bit_q;
	assign rsp.free_remaining = rsp_free_q;
	assign rsp.status         = rsp_status_q;

endmodule

`default_nettype wire
